// ----- rtl/core/tct_pkg.sv -----
// Shared types, codes and helpers for the transpose cache table.
// Used by tct_cell and transpose_cache_table; no dependencies.
package tct_pkg;

   localparam int CAP_W     = 5;
   localparam int DEF_SLOTS = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // operation codes
   localparam logic [2:0] OP_LOOKUP = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_WRITE  = 3'd2;
   localparam logic [2:0] OP_READ   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_MISS  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic [15:0] fnum;
      logic [62:0] offs;
      logic [63:0] stmp;
   } tag_type;

   typedef struct packed {
      logic        valid;
      tag_type     tag;
      logic [31:0] val;
      logic [7:0]  flg;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic write;
      logic take_lo;
      logic take_hi;
      logic halt;
   } cell_ctl_type;

   // zero acts as one, anything above the slot count acts as the slot count
   function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] c, input int slots);
      logic [CAP_W-1:0] r;
      r = c;
      if (c == '0) r = CAP_W'(1);
      else if (32'(c) > slots) r = CAP_W'(slots);
      return r;
   endfunction

endpackage

// ----- rtl/core/tct_cell.sv -----
// One slot of the cache table chain: entry storage, tag compare, scan token.
// Depends on tct_pkg.
module tct_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  tct_pkg::cell_ctl_type ctl,
   input  tct_pkg::entry_type   wr_data,
   input  tct_pkg::tag_type     query,
   input  tct_pkg::entry_type   lower_entry,
   input  tct_pkg::entry_type   upper_entry,
   input  logic                 tok_in,
   output logic                 tok_out,
   output tct_pkg::entry_type   entry,
   output logic                 hit
);
   import tct_pkg::*;

   logic      valid_ff, valid_in;
   entry_type data_ff, data_in;
   logic      tok_ff, tok_in_nx;

   // select the next slot contents: clear, write, swap with a neighbor, or hold
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      priority if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.write) begin
         data_in  = wr_data;
         valid_in = 1'b1;
      end else if (ctl.take_lo) begin
         data_in  = lower_entry;
         valid_in = lower_entry.valid;
      end else if (ctl.take_hi) begin
         data_in  = upper_entry;
         valid_in = upper_entry.valid;
      end
   end

   // pass the scan token one cell up each cycle, drop it when the scan ends
   assign tok_in_nx = tok_in & ~ctl.halt;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      entry       = data_ff;
      entry.valid = valid_ff;
   end

   assign tok_out = tok_ff;
   assign hit     = tok_ff & valid_ff & (data_ff.tag == query);

endmodule

// ----- rtl/core/transpose_cache_table.sv -----
// Top level of the transpose cache table: control, response register, cell chain.
// Depends on tct_pkg and tct_cell.
//
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid/req_ready   | operation, tag, value, flags, slot index
//  rsp_    | out       | rsp_valid/rsp_ready   | status, value, flags, tag, entry count
//  csr_    | in        | csr_wr_en             | capacity (5 bits)
//
// Insert, write, read, clear: the response is registered straight from the accepting cycle.
// Lookup: a token walks the cell chain one slot per cycle over the first min(count,
// active capacity) slots; a hit swaps the entry one place down, an empty table misses without a scan.
// A new transaction is accepted once no lookup is scanning and the response register is empty or being taken.
// Reset is synchronous: empty table, count zero, capacity 16.
module transpose_cache_table #(
   parameter int SLOTS = tct_pkg::DEF_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_operation,
   input  logic [15:0]               req_file_number,
   input  logic [62:0]               req_byte_offset,
   input  logic signed [63:0]        req_stamp,
   input  logic [31:0]               req_value_in,
   input  logic [7:0]                req_flags_in,
   input  logic [3:0]                req_slot_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [31:0]               rsp_value_out,
   output logic [7:0]                rsp_flags_out,
   output logic [15:0]               rsp_file_number_out,
   output logic [62:0]               rsp_byte_offset_out,
   output logic signed [63:0]        rsp_stamp_out,
   output logic [tct_pkg::CAP_W-1:0] rsp_entry_count,
   input  logic                      csr_wr_en,
   input  logic [tct_pkg::CAP_W-1:0] csr_wr_data
);
   import tct_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CAP_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CAP_W-1:0] active_ff, active_in;
   tag_type          query_ff, query_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   entry_type        out_ff, out_in;
   logic [CAP_W-1:0] ocount_ff;

   entry_type        entry_w [SLOTS];
   logic [SLOTS-1:0] hit_w;
   logic [SLOTS:0]   tok_chain;
   cell_ctl_type     ctl_w   [SLOTS];

   logic             req_fire, rsp_load, scan_start, scan_halt, swap_go, wr_go, clear_go;
   logic [CAP_W-1:0] lim, wr_sel;
   logic [CMP_W-1:0] sel_cmp;
   entry_type        sel_entry, wr_data;
   logic             idx_bad;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign lim       = (count_ff < active_ff) ? count_ff : active_ff;
   assign idx_bad   = {1'b0, req_slot_index} >= active_ff;

   assign wr_data.valid    = 1'b1;
   assign wr_data.tag.fnum = req_file_number;
   assign wr_data.tag.offs = req_byte_offset;
   assign wr_data.tag.stmp = req_stamp;
   assign wr_data.val      = req_value_in;
   assign wr_data.flg      = req_flags_in;

   // pick one slot: the scan position while scanning, otherwise the request index
   assign sel_cmp = (state_ff == ST_SCAN) ? CMP_W'(pos_ff) : CMP_W'(req_slot_index);

   always_comb begin
      sel_entry = '0;
      for (int k = 0; k < SLOTS; k++) begin
         if (CMP_W'(k) == sel_cmp) sel_entry = entry_w[k];
      end
   end

   // sequence the transaction
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      active_in  = active_ff;
      query_in   = query_ff;
      rsp_load   = 1'b0;
      status_in  = STAT_OK;
      out_in     = '0;
      scan_start = 1'b0;
      scan_halt  = 1'b0;
      swap_go    = 1'b0;
      wr_go      = 1'b0;
      wr_sel     = '0;
      clear_go   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_load = 1'b1;
               unique case (req_operation)
                  OP_LOOKUP: begin
                     status_in = STAT_MISS;
                     query_in  = wr_data.tag;
                     if (lim != '0) begin
                        rsp_load   = 1'b0;
                        scan_start = 1'b1;
                        pos_in     = '0;
                        state_in   = ST_SCAN;
                     end
                  end
                  OP_INSERT: begin
                     wr_go = 1'b1;
                     if (count_ff < active_ff) begin
                        wr_sel   = count_ff;
                        count_in = count_ff + CAP_W'(1);
                     end else begin
                        wr_sel = active_ff - CAP_W'(1);
                     end
                  end
                  OP_WRITE: begin
                     if (idx_bad) begin
                        status_in = STAT_RANGE;
                     end else begin
                        wr_go  = 1'b1;
                        wr_sel = CAP_W'(req_slot_index);
                        if (!sel_entry.valid && count_ff < active_ff) begin
                           count_in = count_ff + CAP_W'(1);
                        end
                     end
                  end
                  OP_READ: begin
                     if (idx_bad) begin
                        status_in = STAT_RANGE;
                     end else if (!sel_entry.valid) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        out_in = sel_entry;
                     end
                  end
                  OP_CLEAR: begin
                     clear_go  = 1'b1;
                     count_in  = '0;
                     active_in = clamp_cap(cap_ff, SLOTS);
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (|hit_w) begin
               // hit: report the entry and swap it one place down
               rsp_load  = 1'b1;
               status_in = STAT_OK;
               out_in    = sel_entry;
               swap_go   = (pos_ff != '0);
               scan_halt = 1'b1;
               state_in  = ST_IDLE;
            end else if (CMP_W'(pos_ff) + CMP_W'(1) >= CMP_W'(lim)) begin
               rsp_load  = 1'b1;
               status_in = STAT_MISS;
               scan_halt = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               pos_in = pos_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // load the capacity register on a CSR write; a clear copies it into the active capacity
   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         count_ff  <= '0;
         cap_ff    <= CAP_RESET;
         active_ff <= clamp_cap(CAP_RESET, SLOTS);
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         cap_ff    <= cap_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff <= query_in;
   end

   // response register: load on finish, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff <= status_in;
         out_ff    <= out_in;
         ocount_ff <= count_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_value_out       = out_ff.val;
   assign rsp_flags_out       = out_ff.flg;
   assign rsp_file_number_out = out_ff.tag.fnum;
   assign rsp_byte_offset_out = out_ff.tag.offs;
   assign rsp_stamp_out       = out_ff.tag.stmp;
   assign rsp_entry_count     = ocount_ff;

   // cell chain
   assign tok_chain[0] = scan_start;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      entry_type lo_w, hi_w;

      if (k == 0) begin : g_lo0
         assign lo_w = '0;
      end else begin : g_lo
         assign lo_w = entry_w[k-1];
      end
      if (k == SLOTS - 1) begin : g_hiN
         assign hi_w = '0;
      end else begin : g_hi
         assign hi_w = entry_w[k+1];
      end

      assign ctl_w[k].clear   = clear_go;
      assign ctl_w[k].write   = wr_go && (CMP_W'(wr_sel) == CMP_W'(k));
      assign ctl_w[k].take_lo = swap_go && (CMP_W'(pos_ff) == CMP_W'(k));
      assign ctl_w[k].take_hi = swap_go && (CMP_W'(pos_ff) == CMP_W'(k + 1));
      assign ctl_w[k].halt    = scan_halt;

      tct_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl_w[k]),
         .wr_data     (wr_data),
         .query       (query_ff),
         .lower_entry (lo_w),
         .upper_entry (hi_w),
         .tok_in      (tok_chain[k]),
         .tok_out     (tok_chain[k+1]),
         .entry       (entry_w[k]),
         .hit         (hit_w[k])
      );
   end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for transpose_cache_table: random and directed transactions
// checked against a built-in model of the transposing cache table.
// Depends on tct_pkg and the transpose_cache_table RTL.
`timescale 1ns / 100ps

module testbench;
   import tct_pkg::*;

   localparam int NSLOT = 16;
   localparam int LIMIT = 400000;

   typedef struct {
      logic [2:0]  op;
      logic [15:0] fnum;
      logic [62:0] offs;
      logic [63:0] stmp;
      logic [31:0] val;
      logic [7:0]  flg;
      logic [3:0]  idx;
   } cache_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] val;
      logic [7:0]  flg;
      logic [15:0] fnum;
      logic [62:0] offs;
      logic [63:0] stmp;
      logic [4:0]  count;
   } cache_rsp_type;

   typedef struct {
      logic        valid;
      logic [15:0] fnum;
      logic [62:0] offs;
      logic [63:0] stmp;
      logic [31:0] val;
      logic [7:0]  flg;
   } slot_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [2:0] req_operation;
   logic [15:0] req_file_number;
   logic [62:0] req_byte_offset;
   logic signed [63:0] req_stamp;
   logic [31:0] req_value_in;
   logic [7:0] req_flags_in;
   logic [3:0] req_slot_index;
   logic rsp_valid, rsp_ready;
   logic [1:0] rsp_status;
   logic [31:0] rsp_value_out;
   logic [7:0] rsp_flags_out;
   logic [15:0] rsp_file_number_out;
   logic [62:0] rsp_byte_offset_out;
   logic signed [63:0] rsp_stamp_out;
   logic [CAP_W-1:0] rsp_entry_count;
   logic csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   // model state
   slot_type      table_m [NSLOT];
   int            count_m, cap_reg_m, active_cap_m;
   cache_req_type pending_reqs [$];
   cache_rsp_type expected_rsps [$];
   cache_req_type driven_req;
   int            idle_pct, errors, cycles;
   logic [15:0] tag_fnum [6];
   logic [62:0] tag_offs [6];
   logic [63:0] tag_stmp [6];

   transpose_cache_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_file_number(req_file_number),
      .req_byte_offset(req_byte_offset), .req_stamp(req_stamp),
      .req_value_in(req_value_in), .req_flags_in(req_flags_in),
      .req_slot_index(req_slot_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_value_out(rsp_value_out),
      .rsp_flags_out(rsp_flags_out), .rsp_file_number_out(rsp_file_number_out),
      .rsp_byte_offset_out(rsp_byte_offset_out), .rsp_stamp_out(rsp_stamp_out),
      .rsp_entry_count(rsp_entry_count),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   function automatic int clamp_capacity(int c);
      if (c == 0) return 1;
      if (c > NSLOT) return NSLOT;
      return c;
   endfunction

   function automatic void wipe_table();
      foreach (table_m[i]) table_m[i] = '{1'b0, 16'd0, 63'd0, 64'd0, 32'd0, 8'd0};
      count_m = 0;
      active_cap_m = clamp_capacity(cap_reg_m);
   endfunction

   function automatic slot_type make_slot(cache_req_type r);
      return '{1'b1, r.fnum, r.offs, r.stmp, r.val, r.flg};
   endfunction

   // compute the response of one transaction and advance the table
   function automatic cache_rsp_type predict_table_op(cache_req_type r);
      cache_rsp_type e;
      slot_type t;
      int lim;
      e = '{STAT_OK, 32'd0, 8'd0, 16'd0, 63'd0, 64'd0, 5'd0};
      case (r.op)
         OP_LOOKUP: begin
            lim = (count_m < active_cap_m) ? count_m : active_cap_m;
            e.status = STAT_MISS;
            for (int i = 0; i < lim; i++) begin
               t = table_m[i];
               if (t.valid && t.fnum == r.fnum && t.offs == r.offs && t.stmp == r.stmp) begin
                  e = '{STAT_OK, t.val, t.flg, t.fnum, t.offs, t.stmp, 5'd0};
                  if (i > 0) begin
                     table_m[i] = table_m[i-1];
                     table_m[i-1] = t;
                  end
                  break;
               end
            end
         end
         OP_INSERT: begin
            if (count_m < active_cap_m) begin
               table_m[count_m] = make_slot(r);
               count_m++;
            end else
               table_m[active_cap_m-1] = make_slot(r);
         end
         OP_WRITE: begin
            if (r.idx >= active_cap_m) e.status = STAT_RANGE;
            else begin
               if (!table_m[r.idx].valid && count_m < active_cap_m) count_m++;
               table_m[r.idx] = make_slot(r);
            end
         end
         OP_READ: begin
            if (r.idx >= active_cap_m) e.status = STAT_RANGE;
            else if (!table_m[r.idx].valid) e.status = STAT_EMPTY;
            else begin
               t = table_m[r.idx];
               e = '{STAT_OK, t.val, t.flg, t.fnum, t.offs, t.stmp, 5'd0};
            end
         end
         OP_CLEAR: wipe_table();
         default: ;
      endcase
      e.count = 5'(count_m);
      return e;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // driver: hold the transaction until accepted, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_rsps.push_back(predict_table_op(driven_req));
         if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            driven_req = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_operation <= driven_req.op;
            req_file_number <= driven_req.fnum;
            req_byte_offset <= driven_req.offs;
            req_stamp <= driven_req.stmp;
            req_value_in <= driven_req.val;
            req_flags_in <= driven_req.flg;
            req_slot_index <= driven_req.idx;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      cache_rsp_type e;
      cycles++;
      if (cycles > LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, status %0d", $time, rsp_status);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               check_field("status", 64'(e.status), 64'(rsp_status));
               check_field("value", 64'(e.val), 64'(rsp_value_out));
               check_field("flags", 64'(e.flg), 64'(rsp_flags_out));
               check_field("file_number", 64'(e.fnum), 64'(rsp_file_number_out));
               check_field("byte_offset", 64'(e.offs), 64'(rsp_byte_offset_out));
               check_field("stamp", e.stmp, rsp_stamp_out);
               check_field("entry_count", 64'(e.count), 64'(rsp_entry_count));
            end
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   function automatic cache_req_type build_req(logic [2:0] op, int tag, logic [3:0] idx);
      cache_req_type r;
      r.op = op;
      r.fnum = tag_fnum[tag];
      r.offs = tag_offs[tag];
      r.stmp = tag_stmp[tag];
      r.val = $urandom;
      r.flg = 8'($urandom);
      r.idx = idx;
      return r;
   endfunction

   function automatic cache_req_type random_req(int cap);
      cache_req_type r;
      int w;
      w = $urandom_range(99);
      r = build_req(OP_LOOKUP, $urandom_range(5), 4'($urandom_range(cap)));
      if (w < 40) r.op = OP_LOOKUP;
      else if (w < 65) r.op = OP_INSERT;
      else if (w < 77) r.op = OP_WRITE;
      else if (w < 90) r.op = OP_READ;
      else if (w < 94) r.op = OP_CLEAR;
      else r.op = 3'($urandom_range(7, 5));
      // fresh full-width tag now and then
      if ($urandom_range(9) == 0) begin
         r.fnum = 16'($urandom);
         r.offs = 63'({$urandom, $urandom});
         r.stmp = {$urandom, $urandom};
      end
      if ($urandom_range(7) == 0) r.idx = 4'($urandom);
      return r;
   endfunction

   // idle until every outstanding transaction has completed
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_capacity(int c);
      csr_wr_en <= 1'b1;
      csr_wr_data <= 5'(c);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_reg_m = c;
   endtask

   initial begin
      int caps [8] = '{16, 1, 0, 31, 17, 5, 16, 3};
      cache_req_type r;
      errors = 0;
      cycles = 0;
      idle_pct = 21;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = '0;
      req_file_number = '0;
      req_byte_offset = '0;
      req_stamp = '0;
      req_value_in = '0;
      req_flags_in = '0;
      req_slot_index = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      cap_reg_m = 16;
      wipe_table();
      tag_fnum = '{16'h0000, 16'hFFFF, 16'h1234, 16'h1234, 16'h1235, 16'h8001};
      tag_offs = '{63'd0, {63{1'b1}}, 63'h5A5A, 63'h5A5A, 63'h5A5A, 63'h4000_0000_0000_0000};
      tag_stmp = '{64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd1};
      for (int k = 4; k < 6; k++) begin
         tag_offs[k] = tag_offs[k] ^ 63'({$urandom, $urandom});
         tag_stmp[k] = {$urandom, $urandom};
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, each operation, transposition, empty and unknown cases
      pending_reqs.push_back(build_req(OP_LOOKUP, 0, 0));
      pending_reqs.push_back(build_req(OP_READ, 0, 0));
      pending_reqs.push_back(build_req(OP_INSERT, 0, 0));
      pending_reqs.push_back(build_req(OP_INSERT, 1, 0));
      pending_reqs.push_back(build_req(OP_INSERT, 2, 0));
      pending_reqs.push_back(build_req(OP_LOOKUP, 2, 0));
      pending_reqs.push_back(build_req(OP_LOOKUP, 2, 0));
      pending_reqs.push_back(build_req(OP_LOOKUP, 3, 0));
      pending_reqs.push_back(build_req(OP_WRITE, 4, 15));
      pending_reqs.push_back(build_req(OP_READ, 4, 15));
      pending_reqs.push_back(build_req(OP_READ, 4, 9));
      pending_reqs.push_back(build_req(OP_LOOKUP, 4, 0));
      pending_reqs.push_back(build_req(3'd5, 1, 0));
      pending_reqs.push_back(build_req(3'd7, 1, 0));
      pending_reqs.push_back(build_req(OP_CLEAR, 0, 0));
      pending_reqs.push_back(build_req(OP_READ, 1, 15));
      drain();

      // phases over several capacities; each starts idle and latches via clear
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         pending_reqs.push_back(build_req(OP_CLEAR, 0, 0));
         pending_reqs.push_back(build_req(OP_READ, 0, 15));
         for (int k = 0; k < 2 * clamp_capacity(caps[p]) + 2; k++)
            pending_reqs.push_back(build_req(OP_INSERT, $urandom_range(5), 0));
         for (int k = 0; k < 220; k++) begin
            // a stretch with no idling on either side
            if (p == 3 && k == 40) idle_pct = 0;
            if (p == 3 && k == 160) idle_pct = 21;
            r = random_req(clamp_capacity(caps[p]));
            pending_reqs.push_back(r);
            while (pending_reqs.size() > 4) @(posedge clock);
         end
         drain();
      end

      if (errors == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule
